// ===== rtl/core/assert_macros.svh =====
// shared assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define LZG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define LZG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lzgd_pkg.sv =====
`default_nettype none
package lzgd_pkg;

  // offset widths of the four back-reference classes
  localparam int unsigned NEAR_OFFSET_BITS  = 6;
  localparam int unsigned MID_OFFSET_BITS   = 9;
  localparam int unsigned WIDE_OFFSET_BITS  = 12;
  localparam int unsigned FAR_OFFSET_BITS   = 20;
  localparam int unsigned MAX_LENGTH_PREFIX = 12;

  // history depth is 2**HIST_AW bytes
  localparam int unsigned HIST_AW = 21;

  // chained distance bases
  localparam int unsigned BASE0 = 1;
  localparam int unsigned BASE1 = BASE0 + (1 << NEAR_OFFSET_BITS);
  localparam int unsigned BASE2 = BASE1 + (1 << MID_OFFSET_BITS);
  localparam int unsigned BASE3 = BASE2 + (1 << WIDE_OFFSET_BITS);
  localparam int unsigned DIST_MAX = BASE3 + (1 << FAR_OFFSET_BITS) - 1;
  localparam int unsigned DIST_W = $clog2(DIST_MAX + 1);

  localparam int unsigned OFF_W01 = (NEAR_OFFSET_BITS > MID_OFFSET_BITS) ?
                                    NEAR_OFFSET_BITS : MID_OFFSET_BITS;
  localparam int unsigned OFF_W23 = (WIDE_OFFSET_BITS > FAR_OFFSET_BITS) ?
                                    WIDE_OFFSET_BITS : FAR_OFFSET_BITS;
  localparam int unsigned OFF_W = (OFF_W01 > OFF_W23) ? OFF_W01 : OFF_W23;

  // match length range
  localparam int unsigned LEN_MAX = 3 + 2 * ((1 << MAX_LENGTH_PREFIX) - 1);
  localparam int unsigned LEN_W = $clog2(LEN_MAX + 1);
  localparam int unsigned K_W = $clog2(MAX_LENGTH_PREFIX + 2);

  // operations
  localparam logic OP_FEED    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // result status codes
  localparam logic [2:0] ST_BYTE  = 3'd0;
  localparam logic [2:0] ST_FED   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_NEED  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;
  localparam logic [2:0] ST_ERROR = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFETY     = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] source_byte;
  } item_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [31:0] total_out;
  } item_out_t;

  // where an output byte comes from
  typedef enum logic [1:0] {
    SEL_LIT,
    SEL_MEM,
    SEL_FWD
  } sel_t;

  // decoded work handed from the decoder to the output stage
  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        total_out;
    logic               is_byte;
    sel_t               sel;
    logic [7:0]         lit;
    logic [HIST_AW-1:0] rd_addr;
    logic [HIST_AW-1:0] wr_addr;
  } emit_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/lzgd_queue.sv =====
`default_nettype none
module lzgd_queue import lzgd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     src_valid,
  output logic          src_stall,
  input  wire item_in_t src_item,
  output logic          q_valid,
  output item_in_t      q_item,
  input  wire logic     q_pop
);

  item_in_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // two-entry queue in front of the decoder
  assign src_stall = (count == 2'd2);
  assign push      = src_valid && !src_stall;
  assign q_valid   = (count != 2'd0);
  assign q_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= src_item;
  end

endmodule
`default_nettype wire

// ===== rtl/core/lzgd_decode.sv =====
`default_nettype none
`include "assert_macros.svh"
module lzgd_decode import lzgd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire item_in_t             q_item,
  output logic                      q_pop,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output logic                      req_valid,
  output emit_req_t                 req,
  input  wire logic                 req_ready
);

  typedef enum logic [2:0] {
    PH_DECODING = 3'b001,
    PH_FINISHED = 3'b010,
    PH_ERROR    = 3'b100
  } phase_t;

  localparam int unsigned PE0 = 2 + NEAR_OFFSET_BITS;
  localparam int unsigned PE1 = 3 + MID_OFFSET_BITS;
  localparam int unsigned PE2 = 4 + WIDE_OFFSET_BITS;
  localparam int unsigned PE3 = 4 + FAR_OFFSET_BITS;

  logic [31:0]        dest_limit;
  logic               safety_checks;
  logic [63:0]        bit_window,     bit_window_next;
  logic [6:0]         bits_held,      bits_held_next;
  logic               header_pending, header_pending_next;
  logic [31:0]        bytes_out,      bytes_out_next;
  logic [LEN_W-1:0]   copy_rem,       copy_rem_next;
  logic [DIST_W-1:0]  copy_dist,      copy_dist_next;
  phase_t             phase,          phase_next;
  logic [HIST_AW-1:0] wr_pos,         wr_pos_next;

  logic               fire;

  // token fields, decoded from the window every cycle
  logic [1:0]         cls;
  logic [6:0]         pref;
  logic [6:0]         pe;
  logic [OFF_W-1:0]   off;
  logic               off_ones;
  logic [DIST_W-1:0]  base;
  logic [63:0]        rest;
  logic [K_W-1:0]     k;
  logic [K_W-1:0]     kk;
  logic [63:0]        ext_sh;
  logic [LEN_W-1:0]   ext_mask;
  logic [LEN_W-1:0]   extra;
  logic [LEN_W-1:0]   len;
  logic [DIST_W-1:0]  match_dist;
  logic [6:0]         cnt;
  logic               lim_ovf;
  logic               dist_ovf;

  // step control
  logic               do_lit;
  logic               do_copy;
  logic [DIST_W-1:0]  cd;
  logic [LEN_W-1:0]   crem;
  logic [2:0]         st;

  assign fire      = q_valid && req_ready;
  assign q_pop     = fire;
  assign req_valid = q_valid;
  assign cfg_ready = 1'b1;

  // token field extraction
  always_comb begin
    cls = 2'd3;
    if (!bit_window[1]) cls = 2'd0;
    else if (!bit_window[2]) cls = 2'd1;
    else if (!bit_window[3]) cls = 2'd2;
    case (cls)
      2'd0: begin
        pref     = 7'd2;
        pe       = 7'(PE0);
        off      = OFF_W'(bit_window[2 +: NEAR_OFFSET_BITS]);
        off_ones = &bit_window[2 +: NEAR_OFFSET_BITS];
        base     = DIST_W'(BASE0);
        rest     = bit_window >> PE0;
      end
      2'd1: begin
        pref     = 7'd3;
        pe       = 7'(PE1);
        off      = OFF_W'(bit_window[3 +: MID_OFFSET_BITS]);
        off_ones = &bit_window[3 +: MID_OFFSET_BITS];
        base     = DIST_W'(BASE1);
        rest     = bit_window >> PE1;
      end
      2'd2: begin
        pref     = 7'd4;
        pe       = 7'(PE2);
        off      = OFF_W'(bit_window[4 +: WIDE_OFFSET_BITS]);
        off_ones = &bit_window[4 +: WIDE_OFFSET_BITS];
        base     = DIST_W'(BASE2);
        rest     = bit_window >> PE2;
      end
      default: begin
        pref     = 7'd4;
        pe       = 7'(PE3);
        off      = OFF_W'(bit_window[4 +: FAR_OFFSET_BITS]);
        off_ones = &bit_window[4 +: FAR_OFFSET_BITS];
        base     = DIST_W'(BASE3);
        rest     = bit_window >> PE3;
      end
    endcase
  end

  // gamma length: count of leading ones, then the value bits
  always_comb begin
    k = K_W'(MAX_LENGTH_PREFIX + 1);
    for (int j = MAX_LENGTH_PREFIX; j >= 0; j--) begin
      if (!rest[j]) k = K_W'(j);
    end
    kk         = (k > K_W'(MAX_LENGTH_PREFIX)) ? K_W'(MAX_LENGTH_PREFIX) : k;
    ext_sh     = rest >> (7'(k) + 7'd1);
    ext_mask   = (LEN_W'(1) << k) - LEN_W'(1);
    extra      = LEN_W'(ext_sh) & ext_mask;
    len        = ((cls == 2'd3) ? LEN_W'(3) : LEN_W'(2)) + ext_mask + extra;
    match_dist = DIST_W'(off) + base;
    cnt        = pe + (7'(k) << 1) + 7'd1;
    lim_ovf    = ({1'b0, bytes_out} + 33'(len)) > {1'b0, dest_limit};
    dist_ovf   = 32'(match_dist) > bytes_out;
  end

  // per-transaction state update
  always_comb begin
    bit_window_next     = bit_window;
    bits_held_next      = bits_held;
    header_pending_next = header_pending;
    bytes_out_next      = bytes_out;
    copy_rem_next       = copy_rem;
    copy_dist_next      = copy_dist;
    phase_next          = phase;
    wr_pos_next         = wr_pos;
    do_lit              = 1'b0;
    do_copy             = 1'b0;
    cd                  = copy_dist;
    crem                = copy_rem;
    st                  = ST_NEED;
    case (phase)
      PH_FINISHED: st = ST_DONE;
      PH_ERROR:    st = ST_ERROR;
      PH_DECODING: begin
        if (q_item.operation == OP_FEED) begin
          if (header_pending) begin
            header_pending_next = 1'b0;
            st = ST_FED;
          end else if (bits_held > 7'd56) begin
            st = ST_FULL;
          end else begin
            bit_window_next = bit_window | (64'(q_item.source_byte) << bits_held);
            bits_held_next  = bits_held + 7'd8;
            st = ST_FED;
          end
        end else if (copy_rem != '0) begin
          do_copy = 1'b1;
        end else if (header_pending || bits_held == 7'd0) begin
          st = ST_NEED;
        end else if (!bit_window[0]) begin
          // literal token
          if (bits_held < 7'd9) begin
            st = ST_NEED;
          end else if (safety_checks && bytes_out >= dest_limit) begin
            phase_next = PH_ERROR;
            st = ST_ERROR;
          end else begin
            bit_window_next = bit_window >> 9;
            bits_held_next  = bits_held - 7'd9;
            do_lit = 1'b1;
          end
        end else if (bits_held < pref || bits_held < pe) begin
          st = ST_NEED;
        end else if (cls == 2'd3 && off_ones) begin
          // end of stream marker
          bit_window_next = bit_window >> pe;
          bits_held_next  = bits_held - pe;
          phase_next = PH_FINISHED;
          st = ST_DONE;
        end else if (pe + 7'(kk) >= bits_held) begin
          st = ST_NEED;
        end else if (k > K_W'(MAX_LENGTH_PREFIX)) begin
          phase_next = PH_ERROR;
          st = ST_ERROR;
        end else if (cnt > bits_held) begin
          st = ST_NEED;
        end else if (safety_checks && (lim_ovf || dist_ovf)) begin
          phase_next = PH_ERROR;
          st = ST_ERROR;
        end else begin
          bit_window_next = bit_window >> cnt;
          bits_held_next  = bits_held - cnt;
          cd      = match_dist;
          crem    = len;
          do_copy = 1'b1;
        end
      end
      default: st = ST_ERROR;
    endcase

    req.status  = st;
    req.is_byte = do_lit || do_copy;
    req.sel     = SEL_LIT;
    req.lit     = bit_window[8:1];
    req.wr_addr = wr_pos;
    req.rd_addr = wr_pos - HIST_AW'(cd);
    if (do_copy) begin
      req.sel        = (HIST_AW'(cd) == HIST_AW'(1)) ? SEL_FWD : SEL_MEM;
      copy_rem_next  = crem - LEN_W'(1);
      copy_dist_next = cd;
    end
    if (do_lit || do_copy) begin
      req.status     = ST_BYTE;
      wr_pos_next    = wr_pos + HIST_AW'(1);
      bytes_out_next = bytes_out + 32'd1;
    end
    req.total_out = bytes_out_next;
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_window     <= '0;
      bits_held      <= '0;
      header_pending <= 1'b1;
      bytes_out      <= '0;
      copy_rem       <= '0;
      copy_dist      <= '0;
      phase          <= PH_DECODING;
      wr_pos         <= '0;
    end else if (fire) begin
      bit_window     <= bit_window_next;
      bits_held      <= bits_held_next;
      header_pending <= header_pending_next;
      bytes_out      <= bytes_out_next;
      copy_rem       <= copy_rem_next;
      copy_dist      <= copy_dist_next;
      phase          <= phase_next;
      wr_pos         <= wr_pos_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_limit    <= 32'hFFFF_FFFF;
      safety_checks <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEST_LIMIT: dest_limit    <= cfg_data;
        CFG_SAFETY:     safety_checks <= cfg_data[0];
        default: ;
      endcase
    end
  end

  `LZG_ASSERT(a_wr_pos_track, wr_pos == bytes_out[HIST_AW-1:0], "history pointer lost sync")
  `LZG_ASSERT(a_copy_live, (copy_rem == '0) || (phase == PH_DECODING), "copy left after stream end")
  `LZG_ASSERT_NEXT(a_byte_count, fire && req.is_byte, bytes_out == $past(bytes_out) + 32'd1, "byte count not advanced")

endmodule
`default_nettype wire

// ===== rtl/core/lzgd_emit.sv =====
`default_nettype none
module lzgd_emit import lzgd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  input  wire emit_req_t req,
  output logic           req_ready,
  output logic           res_valid,
  input  wire logic      res_stall,
  output item_out_t      res_item
);

  logic [7:0] hist [2**HIST_AW];
  logic       b_v;
  emit_req_t  b_req;
  logic [7:0] rdata;
  logic [7:0] prev;
  logic [7:0] last_byte;
  logic [7:0] b_byte;
  logic [7:0] emitted;
  logic       take;

  assign req_ready = !b_v || !res_stall;
  assign take      = req_ready && req_valid;

  // byte source select
  always_comb begin
    case (b_req.sel)
      SEL_LIT: b_byte = b_req.lit;
      SEL_MEM: b_byte = rdata;
      SEL_FWD: b_byte = prev;
      default: b_byte = b_req.lit;
    endcase
  end

  // most recent byte written to history, for distance one
  assign emitted = (b_v && b_req.is_byte) ? b_byte : last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (req_ready) begin
      b_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    last_byte <= emitted;
    if (take) begin
      b_req <= req;
      prev  <= emitted;
    end
  end

  // history memory, one read and one write port
  always_ff @(posedge clk) begin
    if (take && req.sel == SEL_MEM) rdata <= hist[req.rd_addr];
    if (b_v && b_req.is_byte) hist[b_req.wr_addr] <= b_byte;
  end

  assign res_valid          = b_v;
  assign res_item.out_byte  = b_req.is_byte ? b_byte : 8'd0;
  assign res_item.status    = b_req.status;
  assign res_item.total_out = b_req.total_out;

endmodule
`default_nettype wire

// ===== rtl/core/lz_gamma_length_decompressor_top.sv =====
`default_nettype none
// LZ decompressor with gamma-coded match lengths. Each transaction either feeds one
// compressed byte (the first one is the header and is skipped) or requests one output
// byte, and every transaction gives exactly one result with a status and the running
// output count. One transaction is taken per clock cycle while the result side
// does not stall: the two-entry input queue feeds a combinational decoder, and the
// output stage reads the 2M x 8 history memory with a registered read while the
// previous byte is forwarded for distance one. The history memory needs
// no clearing. Configuration writes are taken at any time but are meant for idle periods.
module lz_gamma_length_decompressor_top import lzgd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 src_valid,
  output logic                      src_stall,
  input  wire item_in_t             src_item,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output item_out_t                 res_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic      q_valid;
  item_in_t  q_item;
  logic      q_pop;
  logic      req_valid;
  emit_req_t req;
  logic      req_ready;

  // input queue
  lzgd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // token decoder and stream state
  lzgd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  // history and output register
  lzgd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule
`default_nettype wire

// ===== test/lzgd_result_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module lzgd_result_checker import lzgd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 src_valid,
  input  wire logic                 src_stall,
  input  wire item_in_t             src_item,
  input  wire logic                 res_valid,
  input  wire logic                 res_stall,
  input  wire item_out_t            res_item,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output int                        errors,
  output int                        pending,
  output int                        window_bits,
  output bit                        header_wait,
  output int unsigned               copy_left,
  output bit                        stream_over
);

  localparam int unsigned DEPTH = 1 << HIST_AW;

  typedef enum logic [2:0] {
    DECODING = 3'b001,
    FINISHED = 3'b010,
    FAILED   = 3'b100
  } run_phase_t;

  // predicted decoder state
  int unsigned   dest_limit;
  bit            safety_on;
  logic [63:0]   win;
  int unsigned   held;
  int unsigned   bytes_out;
  int unsigned   copy_dist;
  int unsigned   wr_pos;
  run_phase_t    run_phase;
  logic [7:0]    hist [0:DEPTH-1];
  int unsigned   ow [4];
  longint unsigned bases [4];
  item_out_t     expected_results [$];

  initial begin
    ow = '{NEAR_OFFSET_BITS, MID_OFFSET_BITS, WIDE_OFFSET_BITS, FAR_OFFSET_BITS};
    bases = '{BASE0, BASE1, BASE2, BASE3};
  end

  function automatic logic [63:0] bits_at(int unsigned pos, int unsigned n);
    logic [63:0] v;
    if (pos >= 64) return 64'd0;
    v = win >> pos;
    if (n < 64) v &= (64'd1 << n) - 64'd1;
    return v;
  endfunction

  task automatic consume(int unsigned n);
    win = (n >= 64) ? 64'd0 : win >> n;
    held = (n >= held) ? 0 : held - n;
  endtask

  task automatic emit(logic [7:0] b);
    hist[wr_pos] = b;
    wr_pos = (wr_pos + 1 >= DEPTH) ? 0 : wr_pos + 1;
    bytes_out = bytes_out + 1;
  endtask

  task automatic copy_byte(output logic [7:0] b);
    int unsigned d, idx;
    d = copy_dist % DEPTH;
    idx = (wr_pos + DEPTH - d) % DEPTH;
    b = hist[idx];
    emit(b);
    copy_left = copy_left - 1;
  endtask

  // decode one token from the bit window
  task automatic decode_token(output logic [2:0] st, output logic [7:0] b);
    int unsigned h, p, cls, nb, k, len;
    longint unsigned off, match_dist, extra;
    h = held;
    b = 8'd0;
    st = ST_NEED;
    if (h < 1) return;
    if (bits_at(0, 1) == 0) begin
      if (h < 9) return;
      if (safety_on && bytes_out >= dest_limit) begin
        run_phase = FAILED;
        st = ST_ERROR;
        return;
      end
      b = 8'(bits_at(1, 8));
      consume(9);
      emit(b);
      st = ST_BYTE;
      return;
    end
    if (h < 2) return;
    if (bits_at(1, 1) == 0) begin
      cls = 0;
      p = 2;
    end else begin
      if (h < 3) return;
      if (bits_at(2, 1) == 0) begin
        cls = 1;
        p = 3;
      end else begin
        if (h < 4) return;
        cls = (bits_at(3, 1) == 0) ? 2 : 3;
        p = 4;
      end
    end
    nb = ow[cls];
    if (h < p + nb) return;
    off = bits_at(p, nb);
    p += nb;
    if (cls == 3 && off == (64'd1 << nb) - 1) begin
      consume(p);
      run_phase = FINISHED;
      st = ST_DONE;
      return;
    end
    match_dist = off + bases[cls];
    k = 0;
    while (k <= MAX_LENGTH_PREFIX) begin
      if (p + k >= h) return;
      if (bits_at(p + k, 1) == 0) break;
      k++;
    end
    if (k > MAX_LENGTH_PREFIX) begin
      run_phase = FAILED;
      st = ST_ERROR;
      return;
    end
    if (p + 2 * k + 1 > h) return;
    extra = bits_at(p + k + 1, k);
    len = 32'(((cls == 3) ? 3 : 2) + ((1 << k) - 1) + extra);
    if (safety_on && ((64'(bytes_out) + len > 64'(dest_limit)) || match_dist > bytes_out)) begin
      run_phase = FAILED;
      st = ST_ERROR;
      return;
    end
    consume(p + 2 * k + 1);
    copy_left = len;
    copy_dist = 32'(match_dist);
    copy_byte(b);
    st = ST_BYTE;
  endtask

  // expected result of one input transaction
  task automatic predict_result(input item_in_t it, output item_out_t r);
    logic [2:0] st;
    logic [7:0] b;
    b = 8'd0;
    if (run_phase == FINISHED) st = ST_DONE;
    else if (run_phase == FAILED) st = ST_ERROR;
    else if (it.operation == OP_FEED) begin
      if (header_wait) begin
        header_wait = 0;
        st = ST_FED;
      end else if (held > 56) st = ST_FULL;
      else begin
        win |= 64'(it.source_byte) << held;
        held += 8;
        st = ST_FED;
      end
    end else if (copy_left > 0) begin
      copy_byte(b);
      st = ST_BYTE;
    end else if (header_wait) st = ST_NEED;
    else decode_token(st, b);
    r.out_byte = (st == ST_BYTE) ? b : 8'd0;
    r.status = st;
    r.total_out = bytes_out;
  endtask

  // follow every transaction on the three channels
  always @(posedge clk) begin
    item_out_t r, e;
    if (rst) begin
      errors = 0;
      dest_limit = 32'hFFFF_FFFF;
      safety_on = 1;
      win = 64'd0;
      held = 0;
      header_wait = 1;
      bytes_out = 0;
      copy_left = 0;
      copy_dist = 0;
      wr_pos = 0;
      run_phase = DECODING;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEST_LIMIT) dest_limit = cfg_data;
        else if (cfg_index == CFG_SAFETY) safety_on = cfg_data[0];
      end
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %p", res_item);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (res_item.out_byte !== e.out_byte) begin
            $error("out_byte expected %0h actual %0h", e.out_byte, res_item.out_byte);
            errors++;
          end
          if (res_item.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, res_item.status);
            errors++;
          end
          if (res_item.total_out !== e.total_out) begin
            $error("total_out expected %0d actual %0d", e.total_out, res_item.total_out);
            errors++;
          end
        end
      end
      if (src_valid && !src_stall) begin
        predict_result(src_item, r);
        expected_results.push_back(r);
      end
    end
    pending = expected_results.size();
    window_bits = held;
    stream_over = (run_phase != DECODING);
  end

endmodule
`default_nettype wire

// ===== test/lz_gamma_length_decompressor_top_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module lz_gamma_length_decompressor_top_test;
  import lzgd_pkg::*;

  localparam int LIMIT = 2000000;

  logic clk, rst;
  logic src_valid, src_stall, res_valid, res_stall, cfg_valid, cfg_ready;
  item_in_t src_item;
  item_out_t res_item;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  int errors, pending, window_bits;
  bit header_wait, stream_over;
  int unsigned copy_left;

  bit quiet = 0;
  bit hold_req = 0;
  int cycles = 0;

  // encoded stream waiting to be fed, and the number of bytes it decodes to
  bit stream_bits [$];
  int unsigned enc_out = 0;
  int unsigned ow [4];
  int unsigned bases [4];

  lz_gamma_length_decompressor_top dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  lzgd_result_checker result_check (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .window_bits(window_bits),
    .header_wait(header_wait), .copy_left(copy_left), .stream_over(stream_over)
  );

  // clock
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side stalls, with one long hold on request
  initial begin
    bit hold_done;
    hold_done = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        res_stall <= 1'b1;
        repeat (300) @(negedge clk);
        res_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        res_stall <= 1'b0;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic push_bits(longint unsigned v, int n);
    for (int i = 0; i < n; i++) stream_bits.push_back(v[i]);
  endtask

  task automatic add_literal(logic [7:0] v);
    stream_bits.push_back(1'b0);
    push_bits(v, 8);
    enc_out++;
  endtask

  task automatic add_match(int cls, int unsigned distance, int k, int unsigned extra);
    for (int i = 0; i <= cls; i++) stream_bits.push_back(1'b1);
    if (cls < 3) stream_bits.push_back(1'b0);
    push_bits(distance - bases[cls], ow[cls]);
    for (int i = 0; i < k; i++) stream_bits.push_back(1'b1);
    stream_bits.push_back(1'b0);
    push_bits(extra, k);
    enc_out += ((cls == 3) ? 3 : 2) + ((1 << k) - 1) + extra;
  endtask

  // well-formed token with a distance inside the data written so far
  task automatic add_random_token();
    int maxc, c, k;
    int unsigned hi, distance, extra;
    if (enc_out == 0 || $urandom_range(0, 9) < 4) begin
      add_literal(8'($urandom));
      return;
    end
    maxc = 0;
    for (int i = 1; i < 4; i++) if (bases[i] <= enc_out) maxc = i;
    c = $urandom_range(0, maxc);
    hi = bases[c] + (1 << ow[c]) - 1;
    if (c == 3) hi--;
    if (hi > enc_out) hi = enc_out;
    distance = $urandom_range(bases[c], hi);
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
    extra = (k > 0) ? $urandom_range(0, (1 << k) - 1) : 0;
    add_match(c, distance, k, extra);
  endtask

  task automatic send(logic op, logic [7:0] b);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    src_valid <= 1'b1;
    src_item <= '{operation: op, source_byte: b};
    do @(posedge clk); while (src_stall);
    @(negedge clk);
  endtask

  task automatic next_byte(output logic [7:0] b);
    b = 8'($urandom);
    if (header_wait) return;
    for (int i = 0; i < 8; i++) if (stream_bits.size() > 0) b[i] = stream_bits.pop_front();
  endtask

  // one transaction: feed the stream, probe a full window, or ask for a byte
  task automatic run_item(bit grow, bit pad);
    bit room;
    logic [7:0] b;
    room = header_wait || window_bits <= 56;
    if (grow) while (stream_bits.size() < 64) add_random_token();
    if (room && (header_wait || stream_bits.size() >= 8 || pad) &&
        $urandom_range(0, 99) < ((window_bits < 24) ? 70 : 30)) begin
      next_byte(b);
      send(OP_FEED, b);
    end else if (!room && $urandom_range(0, 9) == 0) begin
      send(OP_FEED, 8'($urandom));
    end else begin
      send(OP_REQUEST, 8'($urandom));
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    src_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    int mode, c;
    int unsigned far_dist;
    ow = '{NEAR_OFFSET_BITS, MID_OFFSET_BITS, WIDE_OFFSET_BITS, FAR_OFFSET_BITS};
    bases = '{BASE0, BASE1, BASE2, BASE3};
    rst = 1'b1;
    src_valid = 1'b0;
    src_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEST_LIMIT;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(CFG_DEST_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_SAFETY, 32'd1);

    // directed tokens: literal extremes, the near class at its offset edges, the mid
    // class at its lowest offset, short and long lengths
    add_literal(8'h00);
    add_literal(8'hFF);
    add_match(0, 1, 0, 0);
    add_match(0, 2, 5, 31);
    add_match(0, 64, 0, 0);
    add_match(1, BASE1, 1, 0);
    add_match(1, enc_out, 2, 3);
    add_literal(8'h5A);
    while (stream_bits.size() >= 8 || copy_left != 0) run_item(0, 0);

    // unchecked with the lowest limit
    write_reg(CFG_SAFETY, 32'd0);
    write_reg(CFG_DEST_LIMIT, 32'd0);
    repeat (300) run_item(1, 0);

    // checked again, long result hold at the start
    write_reg(CFG_DEST_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_SAFETY, 32'd1);
    hold_req = 1;
    for (int i = 0; i < 400; i++) begin
      if (i == 300) quiet = 1;
      run_item(1, 0);
    end

    // close the stream: end marker, length prefix too long, distance too far,
    // or destination overflow
    mode = $urandom_range(0, 3);
    case (mode)
      0: begin
        push_bits(4'hF, 4);
        push_bits((1 << FAR_OFFSET_BITS) - 1, FAR_OFFSET_BITS);
      end
      1: begin
        push_bits(2'b01, 2);
        push_bits(0, NEAR_OFFSET_BITS);
        for (int i = 0; i <= MAX_LENGTH_PREFIX; i++) stream_bits.push_back(1'b1);
        stream_bits.push_back(1'b0);
      end
      2: begin
        far_dist = enc_out + 1 + $urandom_range(0, 2);
        c = 0;
        for (int i = 1; i < 4; i++) if (bases[i] <= far_dist) c = i;
        add_match(c, far_dist, 0, 0);
      end
      default: begin
        write_reg(CFG_DEST_LIMIT, enc_out + $urandom_range(0, 3));
      end
    endcase
    while (!stream_over) run_item(mode == 3, 1);
    repeat (20) run_item(0, 1);

    // drain
    src_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lzgd_pkg.sv
rtl/core/lzgd_queue.sv
rtl/core/lzgd_decode.sv
rtl/core/lzgd_emit.sv
rtl/core/lz_gamma_length_decompressor_top.sv
test/lzgd_result_checker.sv
test/lz_gamma_length_decompressor_top_test.sv
